FILE: src/ets_pkg.sv
// Package for the eligibility-trace synapse table.
// Holds shared sizes, operation and status codes, controller states and command types.
// Depends on nothing.
`default_nettype none
package ets_pkg;
	localparam int unsigned DEPTH_DEF = 256;
	localparam logic [16:0] TRACE_ONE = 17'd65536;
	localparam logic [16:0] TRACE_THRESH = 17'd6553;
	localparam logic [15:0] FLOOR_RST = 16'd0;
	localparam logic [15:0] CEIL_RST = 16'd4096;
	localparam logic [15:0] GAIN_RST = 16'd5243;
	localparam int unsigned PADDR_W = 4;
	localparam logic [PADDR_W-1:0] ADDR_FLOOR = 4'd0;
	localparam logic [PADDR_W-1:0] ADDR_CEIL = 4'd4;
	localparam logic [PADDR_W-1:0] ADDR_GAIN = 4'd8;

	localparam logic [2:0] MODE_REG = 3'd0;
	localparam logic [2:0] MODE_UNREG = 3'd1;
	localparam logic [2:0] MODE_SPIKE = 3'd2;
	localparam logic [2:0] MODE_DECAY = 3'd3;
	localparam logic [2:0] MODE_CONV = 3'd4;
	localparam logic [2:0] MODE_READ = 3'd5;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISP, ST_RG, ST_LK_RD, ST_LK_CMP, ST_UN_RD, ST_UN_WR,
		ST_DC_RD, ST_DC_WR, ST_CV_RD, ST_CV_M1, ST_CV_M2, ST_CV_WR, ST_FIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic rd_last;
		logic idx_inc;
		logic wr_reg;
		logic set_full;
		logic set_miss;
		logic hit_read;
		logic spk;
		logic wr_un;
		logic wr_dec;
		logic cv_m1;
		logic cv_m2;
		logic wr_cv;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic idx_done;
		logic id_hit;
		logic full;
		logic out_free;
	} stat_t;
endpackage
`default_nettype wire

FILE: src/ets_if.sv
// Channel interfaces for the synapse table: input operation and result.
// Depends on nothing.
`default_nettype none
interface ets_in_if;
	logic valid;
	logic ready;
	logic [2:0] mode;
	logic [31:0] target_id;
	logic signed [15:0] seed_weight;
	logic [16:0] decay_factor;
	logic signed [15:0] dopamine;
	modport source(output valid, mode, target_id, seed_weight, decay_factor, dopamine,
		input ready);
	modport sink(input valid, mode, target_id, seed_weight, decay_factor, dopamine,
		output ready);
endinterface

interface ets_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic signed [15:0] weight;
	logic [16:0] trace;
	logic [8:0] entry_count;
	modport source(output valid, status, weight, trace, entry_count, input ready);
	modport sink(input valid, status, weight, trace, entry_count, output ready);
endinterface
`default_nettype wire

FILE: src/ets_cfg.sv
// APB configuration registers: weight floor, weight ceiling, conversion gain.
// Depends on ets_pkg.
`default_nettype none
module ets_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ets_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic signed [15:0] floor_q,
	output logic signed [15:0] ceil_q,
	output logic [15:0] gain_q
);
	logic wr;
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= ets_pkg::FLOOR_RST;
			ceil_q <= ets_pkg::CEIL_RST;
			gain_q <= ets_pkg::GAIN_RST;
		end else if (wr) begin
			if (paddr == ets_pkg::ADDR_FLOOR) floor_q <= pwdata[15:0];
			if (paddr == ets_pkg::ADDR_CEIL) ceil_q <= pwdata[15:0];
			if (paddr == ets_pkg::ADDR_GAIN) gain_q <= pwdata[15:0];
		end
	end

	always_comb begin
		case (paddr)
			ets_pkg::ADDR_FLOOR: prdata = {16'd0, floor_q};
			ets_pkg::ADDR_CEIL: prdata = {16'd0, ceil_q};
			ets_pkg::ADDR_GAIN: prdata = {16'd0, gain_q};
			default: prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/ets_ctrl.sv
// Controller state machine for the synapse table: sequences each operation.
// Depends on ets_pkg.
`default_nettype none
module ets_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire ets_pkg::stat_t st,
	output ets_pkg::cmd_t cmd
);
	ets_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ets_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ets_pkg::ST_IDLE: if (in_valid) state_d = ets_pkg::ST_DISP;
			ets_pkg::ST_DISP: begin
				case (st.mode)
					ets_pkg::MODE_REG: state_d = ets_pkg::ST_RG;
					ets_pkg::MODE_UNREG, ets_pkg::MODE_SPIKE,
					ets_pkg::MODE_READ: state_d = ets_pkg::ST_LK_RD;
					ets_pkg::MODE_DECAY: state_d = ets_pkg::ST_DC_RD;
					ets_pkg::MODE_CONV: state_d = ets_pkg::ST_CV_RD;
					default: state_d = ets_pkg::ST_FIN;
				endcase
			end
			ets_pkg::ST_RG: state_d = ets_pkg::ST_FIN;
			ets_pkg::ST_LK_RD: state_d = st.idx_done ? ets_pkg::ST_FIN : ets_pkg::ST_LK_CMP;
			ets_pkg::ST_LK_CMP: begin
				if (!st.id_hit) state_d = ets_pkg::ST_LK_RD;
				else if (st.mode == ets_pkg::MODE_UNREG) state_d = ets_pkg::ST_UN_RD;
				else state_d = ets_pkg::ST_FIN;
			end
			ets_pkg::ST_UN_RD: state_d = ets_pkg::ST_UN_WR;
			ets_pkg::ST_UN_WR: state_d = ets_pkg::ST_FIN;
			ets_pkg::ST_DC_RD: state_d = st.idx_done ? ets_pkg::ST_FIN : ets_pkg::ST_DC_WR;
			ets_pkg::ST_DC_WR: state_d = ets_pkg::ST_DC_RD;
			ets_pkg::ST_CV_RD: state_d = st.idx_done ? ets_pkg::ST_FIN : ets_pkg::ST_CV_M1;
			ets_pkg::ST_CV_M1: state_d = ets_pkg::ST_CV_M2;
			ets_pkg::ST_CV_M2: state_d = ets_pkg::ST_CV_WR;
			ets_pkg::ST_CV_WR: state_d = ets_pkg::ST_CV_RD;
			ets_pkg::ST_FIN: if (st.out_free) state_d = ets_pkg::ST_IDLE;
			default: state_d = ets_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ets_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ets_pkg::ST_RG: begin
				cmd.set_full = st.full;
				cmd.wr_reg = !st.full;
			end
			ets_pkg::ST_LK_RD: begin
				cmd.rd_en = !st.idx_done;
				cmd.set_miss = st.idx_done;
			end
			ets_pkg::ST_LK_CMP: begin
				cmd.idx_inc = !st.id_hit;
				cmd.spk = st.id_hit && (st.mode == ets_pkg::MODE_SPIKE);
				cmd.hit_read = st.id_hit && (st.mode == ets_pkg::MODE_READ);
			end
			ets_pkg::ST_UN_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_last = 1'b1;
			end
			ets_pkg::ST_UN_WR: cmd.wr_un = 1'b1;
			ets_pkg::ST_DC_RD, ets_pkg::ST_CV_RD: cmd.rd_en = !st.idx_done;
			ets_pkg::ST_DC_WR: begin
				cmd.wr_dec = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ets_pkg::ST_CV_M1: cmd.cv_m1 = 1'b1;
			ets_pkg::ST_CV_M2: cmd.cv_m2 = 1'b1;
			ets_pkg::ST_CV_WR: begin
				cmd.wr_cv = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ets_pkg::ST_FIN: cmd.load_out = st.out_free;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/ets_dp.sv
// Datapath for the synapse table: entry memories, walk index, count, arithmetic, result register.
// Depends on ets_pkg and the result channel interface.
`default_nettype none
module ets_dp #(
	parameter int unsigned DEPTH = ets_pkg::DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [2:0] in_mode,
	input wire logic [31:0] in_id,
	input wire logic signed [15:0] in_iw,
	input wire logic [16:0] in_factor,
	input wire logic signed [15:0] in_da,
	input wire logic signed [15:0] floor_q,
	input wire logic signed [15:0] ceil_q,
	input wire logic [15:0] gain_q,
	input wire ets_pkg::cmd_t cmd,
	output ets_pkg::stat_t st,
	ets_out_if.source out_ch
);
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [31:0] id_mem [DEPTH];
	logic [15:0] w_mem [DEPTH];
	logic [16:0] tr_mem [DEPTH];

	logic [2:0] mode_q;
	logic [31:0] id_q;
	logic signed [15:0] iw_q;
	logic [16:0] fac_q;
	logic signed [15:0] da_q;
	logic [CW-1:0] idx_q, cnt_q;
	logic [31:0] id_rd_q;
	logic signed [15:0] w_rd_q;
	logic [16:0] tr_rd_q;
	logic [1:0] res_st_q;
	logic signed [15:0] res_w_q;
	logic [16:0] res_tr_q;
	logic out_valid_q;

	logic signed [33:0] p1_s1;
	logic thr_s1, thr_s2;
	logic signed [15:0] w_s1, w_s2;
	logic signed [50:0] p2_s2;

	logic [CW-1:0] last;
	logic [AW-1:0] raddr, waddr;
	logic [33:0] dec_prod;
	logic [16:0] dec_tr;
	logic [50:0] mag;
	logic [19:0] q_mag;
	logic signed [21:0] v_sum;
	logic signed [15:0] cv_w;

	assign last = cnt_q - CW'(1);
	assign raddr = cmd.rd_last ? last[AW-1:0] : idx_q[AW-1:0];
	assign waddr = cmd.wr_reg ? cnt_q[AW-1:0] : idx_q[AW-1:0];

	assign st.mode = mode_q;
	assign st.idx_done = idx_q >= cnt_q;
	assign st.id_hit = id_rd_q == id_q;
	assign st.full = cnt_q >= DEPTH_C;
	assign st.out_free = !out_valid_q || out_ch.ready;

	assign dec_prod = tr_rd_q * fac_q;
	assign dec_tr = dec_prod[32:16];
	assign mag = p2_s2[50] ? 51'(-p2_s2) : 51'(p2_s2);
	assign q_mag = 20'((mag + 51'h80000000) >> 32);
	assign v_sum = 22'(w_s2) + (p2_s2[50] ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag}));
	always_comb begin
		if (v_sum < 22'(floor_q)) cv_w = floor_q;
		else if (v_sum > 22'(ceil_q)) cv_w = ceil_q;
		else cv_w = v_sum[15:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			id_rd_q <= id_mem[raddr];
			w_rd_q <= w_mem[raddr];
			tr_rd_q <= tr_mem[raddr];
		end
		if (cmd.wr_reg || cmd.wr_un) id_mem[waddr] <= cmd.wr_reg ? id_q : id_rd_q;
		if (cmd.wr_reg || cmd.wr_un || (cmd.wr_cv && thr_s2))
			w_mem[waddr] <= cmd.wr_reg ? iw_q : (cmd.wr_un ? w_rd_q : cv_w);
		if (cmd.wr_reg || cmd.wr_un || cmd.spk || cmd.wr_dec) begin
			if (cmd.wr_reg) tr_mem[waddr] <= 17'd0;
			else if (cmd.wr_un) tr_mem[waddr] <= tr_rd_q;
			else if (cmd.spk) tr_mem[waddr] <= ets_pkg::TRACE_ONE;
			else tr_mem[waddr] <= dec_tr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			id_q <= in_id;
			iw_q <= in_iw;
			fac_q <= (in_factor > ets_pkg::TRACE_ONE) ? ets_pkg::TRACE_ONE : in_factor;
			da_q <= in_da;
		end
		if (cmd.cv_m1) begin
			p1_s1 <= $signed({1'b0, tr_rd_q}) * da_q;
			thr_s1 <= tr_rd_q > ets_pkg::TRACE_THRESH;
			w_s1 <= w_rd_q;
		end
		if (cmd.cv_m2) begin
			p2_s2 <= p1_s1 * $signed({1'b0, gain_q});
			thr_s2 <= thr_s1;
			w_s2 <= w_s1;
		end
		if (cmd.capture) begin
			res_st_q <= ets_pkg::STAT_OK;
			res_w_q <= 16'sd0;
			res_tr_q <= 17'd0;
		end else if (cmd.set_full) res_st_q <= ets_pkg::STAT_FULL;
		else if (cmd.set_miss) res_st_q <= ets_pkg::STAT_MISS;
		else if (cmd.wr_reg) res_w_q <= iw_q;
		else if (cmd.spk) begin
			res_w_q <= w_rd_q;
			res_tr_q <= ets_pkg::TRACE_ONE;
		end else if (cmd.hit_read) begin
			res_w_q <= w_rd_q;
			res_tr_q <= tr_rd_q;
		end
		if (cmd.load_out) begin
			out_ch.status <= res_st_q;
			out_ch.weight <= res_w_q;
			out_ch.trace <= res_tr_q;
			out_ch.entry_count <= 9'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_reg) cnt_q <= cnt_q + CW'(1);
			else if (cmd.wr_un) cnt_q <= last;
			if (cmd.capture) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + CW'(1);
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid = out_valid_q;
endmodule
`default_nettype wire

FILE: src/eligibility_trace_synapse_table_core.sv
// Top level of the eligibility-trace synapse table: controller, datapath, configuration port.
// Depends on ets_pkg, the channel interfaces, ets_cfg, ets_ctrl and ets_dp.
// One operation is in flight at a time; all entries sit in single-port memories and are
// walked one per step. Register passes dispatch, a register step and a finish state; read,
// spike and unregister alternate an entry read and an ID compare up to the match, or to the
// end on a miss, and unregister then moves the last entry into the freed slot; a decay tick
// reads and writes back each live entry; a conversion puts the two-stage multiply between
// read and write. The next operation is accepted while a result waits; a result still
// waiting when the next is done holds that one in the finish state until the output frees.
`default_nettype none
module eligibility_trace_synapse_table_core #(
	parameter int unsigned TABLE_DEPTH = ets_pkg::DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ets_in_if.sink in_ch,
	ets_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ets_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic signed [15:0] floor_q, ceil_q;
	logic [15:0] gain_q;
	ets_pkg::cmd_t cmd;
	ets_pkg::stat_t st;

	ets_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.floor_q, .ceil_q, .gain_q
	);

	ets_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .st, .cmd
	);

	ets_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
		.clk, .arst_n,
		.in_mode(in_ch.mode), .in_id(in_ch.target_id), .in_iw(in_ch.seed_weight),
		.in_factor(in_ch.decay_factor), .in_da(in_ch.dopamine),
		.floor_q, .ceil_q, .gain_q, .cmd, .st, .out_ch
	);
endmodule
`default_nettype wire

FILE: src/ets_chk.sv
// Port-level checker for the synapse table core, bound to the top level.
// Depends on ets_pkg.
`default_nettype none
module ets_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] status,
	input wire logic [15:0] weight,
	input wire logic [16:0] trace,
	input wire logic [8:0] entry_count
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
		else $error("result dropped while stalled");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ets_pkg::STAT_OK |-> weight == 16'd0 && trace == 17'd0)
		else $error("failed transaction carries entry data");
	a_trace: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> trace <= ets_pkg::TRACE_ONE)
		else $error("trace above one");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ets_pkg::STAT_FULL |-> entry_count != 9'd0 || trace == 17'd0)
		else $error("full reported with bad trace");
endmodule

bind eligibility_trace_synapse_table_core ets_chk u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.status), .weight(out_ch.weight), .trace(out_ch.trace),
	.entry_count(out_ch.entry_count)
);
`default_nettype wire

FILE: bench/eligibility_trace_synapse_table_core_test.sv
// Testbench for the eligibility-trace synapse table core: directed and random operations,
// APB register setups between phases, results checked against an in-bench table predictor.
// Depends on ets_pkg, the channel interfaces and the core.
`timescale 1ns / 1ps
module eligibility_trace_synapse_table_core_test;
	localparam int DEPTH = int'(ets_pkg::DEPTH_DEF);
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [2:0] mode;
		logic [31:0] target_id;
		logic signed [15:0] seed_weight;
		logic [16:0] decay_factor;
		logic signed [15:0] dopamine;
	} op_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [15:0] weight;
		logic [16:0] trace;
		logic [8:0] entry_count;
	} result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ets_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ets_in_if in_ch();
	ets_out_if out_ch();

	eligibility_trace_synapse_table_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	op_t pending_ops[$];
	result_t expected_results[$];
	int mismatches = 0;

	// table shadow
	logic [31:0] tbl_id[DEPTH];
	int tbl_weight[DEPTH];
	int tbl_start[DEPTH];
	int unsigned tbl_trace[DEPTH];
	int live;
	int w_floor = 0;
	int w_ceil = 4096;
	int unsigned gain = 5243;

	// generator's view of the table
	logic [31:0] gen_ids[$];
	logic [31:0] id_pool[10];

	function automatic int find_slot(input logic [31:0] id);
		for (int i = 0; i < live; i++)
			if (tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic int convert_weight(input int w, input int unsigned tr, input int da);
		longint p, m, q, v;
		p = longint'(tr) * longint'(da) * longint'(gain);
		m = (p < 0) ? -p : p;
		q = (m + 64'h8000_0000) >>> 32;
		v = longint'(w) + ((p < 0) ? -q : q);
		if (v < w_floor) return w_floor;
		if (v > w_ceil) return w_ceil;
		return int'(v);
	endfunction

	function automatic result_t apply_op(input op_t o);
		result_t r;
		int slot;
		int unsigned fac;
		r = '0;
		fac = (o.decay_factor > 17'd65536) ? 65536 : o.decay_factor;
		case (o.mode)
			ets_pkg::MODE_REG: begin
				if (live >= DEPTH) begin
					r.status = ets_pkg::STAT_FULL;
				end else begin
					tbl_id[live] = o.target_id;
					tbl_weight[live] = o.seed_weight;
					tbl_start[live] = o.seed_weight;
					tbl_trace[live] = 0;
					live++;
					r.weight = o.seed_weight;
				end
			end
			ets_pkg::MODE_UNREG: begin
				slot = find_slot(o.target_id);
				if (slot < 0) begin
					r.status = ets_pkg::STAT_MISS;
				end else begin
					tbl_id[slot] = tbl_id[live-1];
					tbl_weight[slot] = tbl_weight[live-1];
					tbl_start[slot] = tbl_start[live-1];
					tbl_trace[slot] = tbl_trace[live-1];
					live--;
				end
			end
			ets_pkg::MODE_SPIKE, ets_pkg::MODE_READ: begin
				slot = find_slot(o.target_id);
				if (slot < 0) begin
					r.status = ets_pkg::STAT_MISS;
				end else begin
					if (o.mode == ets_pkg::MODE_SPIKE) tbl_trace[slot] = 65536;
					r.weight = tbl_weight[slot][15:0];
					r.trace = tbl_trace[slot][16:0];
				end
			end
			ets_pkg::MODE_DECAY: begin
				for (int i = 0; i < live; i++)
					tbl_trace[i] = int'((longint'(tbl_trace[i]) * fac) >>> 16);
			end
			ets_pkg::MODE_CONV: begin
				for (int i = 0; i < live; i++)
					if (tbl_trace[i] > ets_pkg::TRACE_THRESH)
						tbl_weight[i] = convert_weight(tbl_weight[i], tbl_trace[i],
							o.dopamine);
			end
			default: ;
		endcase
		r.entry_count = live[8:0];
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	int send_gap = 0;
	bit send_burst = 0;
	always @(posedge clk or negedge arst_n) begin
		op_t nxt;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(apply_op({in_ch.mode, in_ch.target_id,
					in_ch.seed_weight, in_ch.decay_factor, in_ch.dopamine}));
				if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
				send_gap = send_burst ? 0 : $urandom_range(0, 7);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					nxt = pending_ops.pop_front();
					in_ch.mode <= nxt.mode;
					in_ch.target_id <= nxt.target_id;
					in_ch.seed_weight <= nxt.seed_weight;
					in_ch.decay_factor <= nxt.decay_factor;
					in_ch.dopamine <= nxt.dopamine;
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int stall = 0;
	bit recv_burst = 0;
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction");
					mismatches++;
				end else begin
					e = expected_results.pop_front();
					if (out_ch.status !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status, out_ch.status);
						mismatches++;
					end
					if (out_ch.weight !== e.weight) begin
						$error("weight: expected %0d, actual %0d", e.weight, out_ch.weight);
						mismatches++;
					end
					if (out_ch.trace !== e.trace) begin
						$error("trace: expected %0d, actual %0d", e.trace, out_ch.trace);
						mismatches++;
					end
					if (out_ch.entry_count !== e.entry_count) begin
						$error("entry_count: expected %0d, actual %0d", e.entry_count,
							out_ch.entry_count);
						mismatches++;
					end
				end
				if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
				stall = recv_burst ? 0 : $urandom_range(0, 7);
			end
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(pending_ops.size() == 0 && expected_results.size() == 0 && !in_ch.valid))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic add_op(input logic [2:0] mode, input logic [31:0] id,
			input logic [15:0] iw, input logic [16:0] fac, input logic [15:0] da);
		int k;
		pending_ops.push_back({mode, id, iw, fac, da});
		if (mode == ets_pkg::MODE_REG && gen_ids.size() < DEPTH) gen_ids.push_back(id);
		if (mode == ets_pkg::MODE_UNREG) begin
			k = -1;
			foreach (gen_ids[j]) if (k < 0 && gen_ids[j] == id) k = j;
			if (k >= 0) gen_ids.delete(k);
		end
	endtask

	task automatic settle();
		wait (pending_ops.size() == 0 && expected_results.size() == 0 && !in_ch.valid);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ets_pkg::PADDR_W-1:0] addr,
			input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'($urandom_range(0, 65535)), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ets_pkg::ADDR_FLOOR) w_floor = $signed(value);
		else if (addr == ets_pkg::ADDR_CEIL) w_ceil = $signed(value);
		else gain = value;
	endtask

	task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] g);
		settle();
		apb_write(ets_pkg::ADDR_FLOOR, lo);
		apb_write(ets_pkg::ADDR_CEIL, hi);
		apb_write(ets_pkg::ADDR_GAIN, g);
	endtask

	function automatic logic [31:0] pick_id();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7 && gen_ids.size() > 0) return gen_ids[$urandom_range(0, gen_ids.size() - 1)];
		if (r < 9) return id_pool[$urandom_range(0, 9)];
		return $urandom;
	endfunction

	function automatic logic [16:0] pick_factor();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return 17'($urandom_range(58000, 65536));
		if (r < 8) return 17'($urandom_range(0, 131071));
		return 17'd65536;
	endfunction

	// reg_pct/unreg_pct shape how the table grows or drains
	task automatic random_phase(input int n, input int reg_pct, input int unreg_pct);
		int r;
		logic [2:0] m;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (gen_ids.size() < 4 && r < 50) m = ets_pkg::MODE_REG;
			else if (r < reg_pct) m = ets_pkg::MODE_REG;
			else if (r < reg_pct + unreg_pct) m = ets_pkg::MODE_UNREG;
			else if (r < 97) m = 3'($urandom_range(2, 5));
			else m = 3'($urandom_range(6, 7));
			add_op(m, (m == ets_pkg::MODE_REG && $urandom_range(0, 3) == 0) ? $urandom : pick_id(),
				16'($urandom), pick_factor(), 16'($urandom));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.mode = '0;
		in_ch.target_id = '0;
		in_ch.seed_weight = '0;
		in_ch.decay_factor = '0;
		in_ch.dopamine = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		live = 0;
		foreach (id_pool[j]) id_pool[j] = $urandom;
		id_pool[0] = 32'h0;
		id_pool[1] = 32'hFFFF_FFFF;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		add_op(ets_pkg::MODE_REG, 32'h0, 16'sh8000, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_REG, 32'hFFFF_FFFF, 16'sh7FFF, 17'h1FFFF, 16'hFFFF);
		add_op(ets_pkg::MODE_REG, 32'h0, 16'd100, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_READ, 32'h0, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_READ, 32'hFFFF_FFFF, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_READ, 32'h5, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_SPIKE, 32'h0, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_SPIKE, 32'h1234_5678, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_DECAY, 32'h0, 16'd0, 17'd65536, 16'd0);
		add_op(ets_pkg::MODE_DECAY, 32'h0, 16'd0, 17'h1FFFF, 16'd0);
		add_op(ets_pkg::MODE_DECAY, 32'h0, 16'd0, 17'd60000, 16'd0);
		add_op(ets_pkg::MODE_CONV, 32'h0, 16'd0, 17'd0, 16'sh7FFF);
		add_op(ets_pkg::MODE_READ, 32'h0, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_CONV, 32'h0, 16'd0, 17'd0, 16'sh8000);
		add_op(ets_pkg::MODE_SPIKE, 32'hFFFF_FFFF, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_DECAY, 32'h0, 16'd0, 17'd6000, 16'd0);
		add_op(ets_pkg::MODE_CONV, 32'h0, 16'd0, 17'd0, 16'sh7FFF);
		add_op(ets_pkg::MODE_UNREG, 32'h0, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_READ, 32'h0, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_UNREG, 32'h7, 16'd0, 17'd0, 16'd0);
		add_op(3'd6, 32'h0, 16'hFFFF, 17'h1FFFF, 16'hFFFF);
		add_op(3'd7, 32'hFFFF_FFFF, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_UNREG, 32'hFFFF_FFFF, 16'd0, 17'd0, 16'd0);
		add_op(ets_pkg::MODE_UNREG, 32'h0, 16'd0, 17'd0, 16'd0);

		settle();
		random_phase(180, 25, 15);
		set_limits(16'h8000, 16'h7FFF, 16'hFFFF);
		random_phase(180, 25, 20);
		set_limits(16'h0000, 16'h0000, 16'h0000);
		random_phase(180, 25, 20);
		set_limits(16'h7FFF, 16'h8000, 16'h0001);
		random_phase(180, 25, 20);
		set_limits(16'hF000, 16'h2000, 16'd40000);
		random_phase(300, 85, 3);
		random_phase(150, 5, 70);
		set_limits(16'($urandom), 16'($urandom), 16'($urandom));
		random_phase(180, 25, 20);

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

FILE: filelist.f
src/ets_pkg.sv
src/ets_if.sv
src/ets_cfg.sv
src/ets_ctrl.sv
src/ets_dp.sv
src/eligibility_trace_synapse_table_core.sv
src/ets_chk.sv
bench/eligibility_trace_synapse_table_core_test.sv
